FILE: hw/rtl/kfmt_pkg.sv
// Shared types and codes for the key frequency min/max table unit.
// Has no dependencies; the top level imports it.
`default_nettype none

package kfmt_pkg;

  typedef enum logic {
    ACT_INC = 1'b0,
    ACT_DEC = 1'b1
  } kfmt_action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_SAT    = 2'd3
  } kfmt_status_e;

endpackage

`default_nettype wire

FILE: hw/rtl/key_frequency_minmax_table_unit.sv
// Top level of the key frequency min/max table unit: slot memories, search and
// min/max scan sequencer, and the output register. Depends on kfmt_pkg.
//
// Usage: each transfer on the slave stream carries one key in tdata and the
// action (0 increment, 1 decrement) in tuser. For each input transfer exactly
// one result transfer leaves on the master stream, carrying the key's new
// count, the keys with the highest and lowest counts (lowest slot wins ties),
// an empty flag and a status code.
// Each item takes two sequential passes over the slot memories, one read per
// cycle through their single read port: one pass to find the key and the first
// free slot, one to find the highest and lowest counts. One item is in work at
// a time; the next item may be taken while the previous result still waits in
// the output register.
// After reset a clearing pass writes a zero count into every slot with the
// input not ready during the pass; a zero count marks a free slot.
// When the receiver stalls, the finished result holds in the output register
// and the sequencer waits before delivering the next.
`default_nettype none

module key_frequency_minmax_table_unit #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           s_axis_tvalid,
  output logic                                          s_axis_tready,
  // Fields from bit 0: key.
  input  wire  [((KEY_BITS + 7) / 8) * 8 - 1:0]         s_axis_tdata,
  // Fields from bit 0: action.
  input  wire                                           s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  wire                                           m_axis_tready,
  // Fields from bit 0: key_count, max_key, min_key, is_empty, status.
  output logic [((COUNT_BITS + 2 * KEY_BITS + 10) / 8) * 8 - 1:0] m_axis_tdata
);
  import kfmt_pkg::*;

  localparam int IDXW     = $clog2(ENTRIES);
  localparam int OUT_BITS = COUNT_BITS + 2 * KEY_BITS + 3;
  localparam int OUT_W    = ((COUNT_BITS + 2 * KEY_BITS + 10) / 8) * 8;
  localparam logic [IDXW:0]         IdxEnd  = (IDXW + 1)'(ENTRIES);
  localparam logic [IDXW:0]         IdxLast = (IDXW + 1)'(ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] CntMax  = '1;
  localparam logic [COUNT_BITS-1:0] CntOne  = COUNT_BITS'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_RDCNT,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q;

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [IDXW-1:0]       rd_addr;
  logic                  key_we, cnt_we;
  logic [IDXW-1:0]       wr_addr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic [IDXW:0]         idx_q;
  logic                  pend_q;
  logic [IDXW-1:0]       pidx_q;
  logic [KEY_BITS-1:0]   key_q;
  kfmt_action_e          act_q;
  logic                  found_q, free_found_q;
  logic [IDXW-1:0]       slot_q, free_q;
  logic [COUNT_BITS-1:0] count_q;
  kfmt_status_e          status_q;
  logic                  any_q;
  logic [COUNT_BITS-1:0] hi_cnt_q, lo_cnt_q;
  logic [KEY_BITS-1:0]   hi_key_q, lo_key_q;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_q;

  logic                  pend_valid;
  logic                  in_xfer;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign pend_valid    = pend_q && (cnt_rd_q != '0);
  assign rd_addr       = (state_q == S_RDCNT) ? slot_q : idx_q[IDXW-1:0];

  // Write side of the clearing pass and of the modify step.
  always_comb begin
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_addr   = slot_q;
    cnt_wdata = cnt_rd_q;
    if (state_q == S_CLEAR) begin
      cnt_we    = 1'b1;
      wr_addr   = idx_q[IDXW-1:0];
      cnt_wdata = '0;
    end else if (state_q == S_MODIFY) begin
      if (act_q == ACT_INC) begin
        if (found_q) begin
          cnt_we    = (cnt_rd_q != CntMax);
          cnt_wdata = cnt_rd_q + CntOne;
        end else if (free_found_q) begin
          key_we    = 1'b1;
          cnt_we    = 1'b1;
          wr_addr   = free_q;
          cnt_wdata = CntOne;
        end
      end else if (found_q) begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_rd_q <= CntOne) ? '0 : cnt_rd_q - CntOne;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pidx_q       <= '0;
      key_q        <= '0;
      act_q        <= ACT_INC;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      slot_q       <= '0;
      free_q       <= '0;
      count_q      <= '0;
      status_q     <= ST_OK;
      any_q        <= 1'b0;
      hi_cnt_q     <= '0;
      lo_cnt_q     <= '0;
      hi_key_q     <= '0;
      lo_key_q     <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (idx_q == IdxLast) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            key_q        <= s_axis_tdata[KEY_BITS-1:0];
            act_q        <= kfmt_action_e'(s_axis_tuser);
            idx_q        <= '0;
            pend_q       <= 1'b0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_FIND;
          end
        end
        S_FIND: begin
          if (pend_q) begin
            if (pend_valid && key_rd_q == key_q && !found_q) begin
              found_q <= 1'b1;
              slot_q  <= pidx_q;
            end
            if (!pend_valid && !free_found_q) begin
              free_found_q <= 1'b1;
              free_q       <= pidx_q;
            end
          end
          if (idx_q == IdxEnd) begin
            pend_q  <= 1'b0;
            state_q <= S_RDCNT;
          end else begin
            pend_q <= 1'b1;
            pidx_q <= idx_q[IDXW-1:0];
            idx_q  <= idx_q + 1'b1;
          end
        end
        S_RDCNT: begin
          state_q <= S_MODIFY;
        end
        S_MODIFY: begin
          count_q  <= '0;
          status_q <= ST_OK;
          if (act_q == ACT_INC) begin
            if (found_q) begin
              if (cnt_rd_q == CntMax) begin
                count_q  <= CntMax;
                status_q <= ST_SAT;
              end else begin
                count_q <= cnt_rd_q + CntOne;
              end
            end else if (free_found_q) begin
              count_q <= CntOne;
            end else begin
              status_q <= ST_FULL;
            end
          end else begin
            if (!found_q) begin
              status_q <= ST_ABSENT;
            end else if (cnt_rd_q > CntOne) begin
              count_q <= cnt_rd_q - CntOne;
            end
          end
          idx_q   <= '0;
          pend_q  <= 1'b0;
          any_q   <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (pend_valid) begin
            any_q <= 1'b1;
            if (!any_q || cnt_rd_q > hi_cnt_q) begin
              hi_cnt_q <= cnt_rd_q;
              hi_key_q <= key_rd_q;
            end
            if (!any_q || cnt_rd_q < lo_cnt_q) begin
              lo_cnt_q <= cnt_rd_q;
              lo_key_q <= key_rd_q;
            end
          end
          if (idx_q == IdxEnd) begin
            pend_q  <= 1'b0;
            state_q <= S_DONE;
          end else begin
            pend_q <= 1'b1;
            pidx_q <= idx_q[IDXW-1:0];
            idx_q  <= idx_q + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_q <= OUT_W'({status_q, !any_q,
                             any_q ? lo_key_q : {KEY_BITS{1'b0}},
                             any_q ? hi_key_q : {KEY_BITS{1'b0}},
                             count_q});
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  localparam int ST_LSB = OUT_BITS - 2;
  localparam int EM_BIT = OUT_BITS - 3;

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  a_full_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[ST_LSB+1:ST_LSB] == ST_FULL
      |-> m_axis_tdata[COUNT_BITS-1:0] == '0)
    else $error("full status with a nonzero count");

  a_empty_zero_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[EM_BIT]
      |-> m_axis_tdata[EM_BIT-1:COUNT_BITS] == '0)
    else $error("empty table reports a key");

  a_sat_max_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[ST_LSB+1:ST_LSB] == ST_SAT
      |-> m_axis_tdata[COUNT_BITS-1:0] == CntMax)
    else $error("saturated status without the largest count");

endmodule

`default_nettype wire
